>>> rtl/pps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pps_pkg: shared types and constants of the previous prime search
// Widths, register indexes, controller states and multiply phases.
// ----------------------------------------------------------------------------
package pps_pkg;

  localparam int W = 32;
  localparam int CW = $clog2(W);
  localparam int NUM_WITNESSES = 3;
  localparam int RW = 2;

  localparam logic [1:0] REG_SEED_A = 2'd0;
  localparam logic [1:0] REG_SEED_B = 2'd1;
  localparam logic [1:0] REG_SEED_C = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CAND,
    ST_TRIAL,
    ST_TEST,
    ST_SPLIT,
    ST_SEED,
    ST_EXP,
    ST_EXPM,
    ST_ADV,
    ST_MUL,
    ST_CHECK,
    ST_LTEST,
    ST_LCHK,
    ST_PASS,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    PH_SQ,
    PH_ML,
    PH_LOOP
  } phase_t;

endpackage

`default_nettype wire

>>> rtl/previous_prime_search_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// previous_prime_search_top: largest probable prime below a bound
// Downward search over odd candidates with trial division by 3 and 5 and
// Miller-Rabin rounds, all arithmetic done one bit per cycle.
// ----------------------------------------------------------------------------
// Usage: raise start with upper_bound while busy is low; the item is taken
// at that edge and busy stays high until the result. The result appears on
// prime_below and bad_input for exactly one cycle with done high; the
// receiver cannot stall it. A bound below three answers 0 with bad_input,
// a bound of three answers 2, both in the cycle right after the accepting edge.
// Per candidate: a serial remainder by 3 and 5 comes first, and a multiple of
// 3 or 5 other than 5 itself is dropped there. A surviving candidate then has
// its powers of two split off; each witness round then takes a serial
// remainder of its seed and does up to 32 x 2 modular multiplies for the
// exponentiation and one more per extra squaring, all on the shared
// bit-serial modular multiplier. Seeds must be written on wr_en/wr_index/
// wr_data only while idle; the block itself does not enforce this.
// Synchronous reset returns to idle with seeds 0, 5 and 59.
// ----------------------------------------------------------------------------
module previous_prime_search_top
  import pps_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  input  wire logic [W-1:0]  upper_bound,
  output logic               done,
  output logic [W-1:0]       prime_below,
  output logic               bad_input,
  input  wire logic          wr_en,
  input  wire logic [1:0]    wr_index,
  input  wire logic [W-1:0]  wr_data
);

  state_t state, state_next;
  phase_t phase;

  logic [W-1:0]  seed_a, seed_b, seed_c;
  logic [W-1:0]  cand, sh, dval, dsh, wit, acc, mb, rem, p;
  logic [CW-1:0] cnt, ecnt, s_cnt, i_cnt;
  logic [1:0]    r3;
  logic [2:0]    r5;
  logic [RW-1:0] round;
  logic          bad;

  // serial remainders by 3 and 5
  logic [2:0] r3_t;
  logic [3:0] r5_t;
  logic [1:0] r3_n;
  logic [2:0] r5_n;
  always_comb begin
    r3_t = {r3, sh[W-1]};
    r5_t = {r5, sh[W-1]};
    r3_n = (r3_t >= 3'd3) ? 2'(r3_t - 3'd3) : r3_t[1:0];
    r5_n = (r5_t >= 4'd5) ? 3'(r5_t - 4'd5) : r5_t[2:0];
  end

  // serial restoring remainder of the seed by cand - 2
  logic [W-1:0] m2;
  logic [W:0]   rem_t;
  logic [W-1:0] rem_n;
  always_comb begin
    m2 = cand - W'(2);
    rem_t = {rem, sh[W-1]};
    rem_n = (rem_t >= {1'b0, m2}) ? W'(rem_t - {1'b0, m2}) : rem_t[W-1:0];
  end

  // bit-serial modular multiply step, multiplier bits msb first
  logic [W:0]   dbl, dbl_r, sum;
  logic [W-1:0] p_n;
  always_comb begin
    dbl = {p, 1'b0};
    dbl_r = (dbl >= {1'b0, cand}) ? dbl - {1'b0, cand} : dbl;
    sum = dbl_r + (sh[W-1] ? {1'b0, mb} : '0);
    p_n = (sum >= {1'b0, cand}) ? W'(sum - {1'b0, cand}) : sum[W-1:0];
  end

  // seed of the current round
  logic [W-1:0] seed_sel;
  always_comb begin
    unique case (round)
      2'd0:    seed_sel = seed_a;
      2'd1:    seed_sel = seed_b;
      default: seed_sel = seed_c;
    endcase
  end

  logic last_bit, last_round, cand_small, reject_small;
  always_comb begin
    last_bit = (cnt == CW'(W - 1));
    last_round = (round == RW'(NUM_WITNESSES - 1));
    cand_small = (cand <= W'(3));
    reject_small = (r3 == 2'd0) || ((r5 == 3'd0) && (cand != W'(5)));
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = (upper_bound <= W'(3)) ? ST_DONE : ST_CAND;
        end
      end
      ST_CAND:  state_next = cand_small ? ST_DONE : ST_TRIAL;
      ST_TRIAL: state_next = last_bit ? ST_TEST : ST_TRIAL;
      ST_TEST:  state_next = reject_small ? ST_CAND : ST_SPLIT;
      ST_SPLIT: state_next = dval[0] ? ST_SEED : ST_SPLIT;
      ST_SEED:  state_next = last_bit ? ST_EXP : ST_SEED;
      ST_EXP:   state_next = ST_MUL;
      ST_EXPM:  state_next = dsh[W-1] ? ST_MUL : ST_ADV;
      ST_ADV:   state_next = (ecnt == CW'(W - 1)) ? ST_CHECK : ST_EXP;
      ST_MUL: begin
        if (last_bit) begin
          unique case (phase)
            PH_SQ:   state_next = ST_EXPM;
            PH_ML:   state_next = ST_ADV;
            default: state_next = ST_LCHK;
          endcase
        end
      end
      ST_CHECK: begin
        state_next = ((acc == W'(1)) || (acc == cand - W'(1))) ? ST_PASS : ST_LTEST;
      end
      ST_LTEST: state_next = (i_cnt < s_cnt) ? ST_MUL : ST_CAND;
      ST_LCHK:  state_next = (acc == cand - W'(1)) ? ST_PASS : ST_LTEST;
      ST_PASS:  state_next = last_round ? ST_DONE : ST_SEED;
      ST_DONE:  state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy = (state != ST_IDLE);
    done = (state == ST_DONE);
    prime_below = cand;
    bad_input = bad;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      seed_a <= W'(0);
      seed_b <= W'(5);
      seed_c <= W'(59);
    end else if (wr_en) begin
      if (wr_index == REG_SEED_A) seed_a <= wr_data;
      if (wr_index == REG_SEED_B) seed_b <= wr_data;
      if (wr_index == REG_SEED_C) seed_c <= wr_data;
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        bad <= 1'b0;
        if (upper_bound < W'(3)) begin
          cand <= '0;
          bad <= 1'b1;
        end else if (upper_bound == W'(3)) begin
          cand <= W'(2);
        end else begin
          cand <= upper_bound[0] ? upper_bound - W'(2) : upper_bound - W'(1);
        end
      end
      ST_CAND: begin
        sh <= cand;
        cnt <= '0;
        r3 <= '0;
        r5 <= '0;
      end
      ST_TRIAL: begin
        r3 <= r3_n;
        r5 <= r5_n;
        sh <= sh << 1;
        cnt <= cnt + CW'(1);
      end
      ST_TEST: begin
        if (reject_small) begin
          cand <= cand - W'(2);
        end
        dval <= cand - W'(1);
        s_cnt <= '0;
        round <= '0;
      end
      ST_SPLIT: begin
        if (!dval[0]) begin
          dval <= dval >> 1;
          s_cnt <= s_cnt + CW'(1);
        end else begin
          sh <= seed_sel;
          rem <= '0;
          cnt <= '0;
        end
      end
      ST_SEED: begin
        rem <= rem_n;
        sh <= sh << 1;
        cnt <= cnt + CW'(1);
        wit <= rem_n + W'(2);
        acc <= W'(1);
        dsh <= dval;
        ecnt <= '0;
      end
      ST_EXP: begin
        sh <= acc;
        mb <= acc;
        p <= '0;
        cnt <= '0;
        phase <= PH_SQ;
      end
      ST_EXPM: begin
        sh <= acc;
        mb <= wit;
        p <= '0;
        cnt <= '0;
        phase <= PH_ML;
      end
      ST_ADV: begin
        dsh <= dsh << 1;
        ecnt <= ecnt + CW'(1);
        i_cnt <= CW'(1);
      end
      ST_MUL: begin
        p <= p_n;
        sh <= sh << 1;
        cnt <= cnt + CW'(1);
        if (last_bit) begin
          acc <= p_n;
        end
      end
      ST_CHECK: begin
        i_cnt <= CW'(1);
      end
      ST_LTEST: begin
        if (i_cnt < s_cnt) begin
          sh <= acc;
          mb <= acc;
          p <= '0;
          cnt <= '0;
          phase <= PH_LOOP;
        end else begin
          cand <= cand - W'(2);
        end
      end
      ST_LCHK: begin
        i_cnt <= i_cnt + CW'(1);
      end
      ST_PASS: begin
        round <= round + RW'(1);
        sh <= (round == 2'd0) ? seed_b : seed_c;
        rem <= '0;
        cnt <= '0;
      end
      ST_DONE: begin
        cnt <= '0;
      end
      default: begin
        cnt <= '0;
      end
    endcase
  end

endmodule

`default_nettype wire
